### hw/rtl/wcrm_pkg.sv
// package for the windowed clock ratio monitor: widths, reset values,
// request and result types, register indexes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package wcrm_pkg;

	// window geometry
	localparam int WINDOW_DEPTH = 30;
	localparam int STEP_W       = 18;
	localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
	localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
	localparam int TOTAL_W      = STEP_W + $clog2(WINDOW_DEPTH);

	// field and register widths
	localparam int STAMP_W    = 32;
	localparam int POS_W      = 24;
	localparam int WARP_W     = 24;
	localparam int TOL_W      = 16;
	localparam int REQ_W      = 4;
	localparam int MINFILL_W  = 5;
	localparam int ARM_W      = 16;
	localparam int GAP_W      = 18;
	localparam int VIOL_W     = 5;
	localparam int OUTFILL_W  = 5;
	localparam int FRAC_W     = 16;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 3;

	// deviation and product width: warp * total dominates
	localparam int DEV_W = WARP_W + TOTAL_W;

	localparam logic [VIOL_W-1:0] VIOL_MAX = '1;

	// register reset values
	localparam logic [WARP_W-1:0]    WARP_RST     = WARP_W'(65536);
	localparam logic [TOL_W-1:0]     SOFT_RST     = TOL_W'(3277);
	localparam logic [TOL_W-1:0]     HARD_RST     = TOL_W'(9830);
	localparam logic [REQ_W-1:0]     REQ_RST      = REQ_W'(4);
	localparam logic [MINFILL_W-1:0] MINFILL_RST  = MINFILL_W'(12);
	localparam logic [ARM_W-1:0]     ARM_RST      = ARM_W'(80);
	localparam logic [GAP_W-1:0]     GAP_RST      = GAP_W'(200000);

	typedef enum logic [1:0] {
		OP_FRAME         = 2'd0,
		OP_PREPARE       = 2'd1,
		OP_CLEAR_SAMPLES = 2'd2,
		OP_CLEAR_ALL     = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WARP      = 3'd0,
		REG_SOFT_TOL  = 3'd1,
		REG_HARD_TOL  = 3'd2,
		REG_REQ_VIOL  = 3'd3,
		REG_MIN_FILL  = 3'd4,
		REG_ARM_DIST  = 3'd5,
		REG_MAX_GAP   = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		op_t                     op;
		logic [STAMP_W-1:0]      now_us;
		logic [STEP_W-1:0]       game_step_us;
		logic signed [POS_W-1:0] player_x;
		logic                    halted;
	} in_item_t;

	typedef struct packed {
		logic                 detected;
		logic [VIOL_W-1:0]    violation_count;
		logic                 is_armed;
		logic [OUTFILL_W-1:0] window_fill;
	} out_item_t;

	// outcome of one ratio judgement
	typedef struct packed {
		logic over_soft;
		logic over_hard;
	} judge_t;

endpackage

`default_nettype wire

### hw/rtl/wcrm_judge.sv
// ratio judgement: compares game total against warp times real total
// without division; depends on wcrm_pkg
`timescale 1ns / 1ps
`default_nettype none

module wcrm_judge (
	input  wire logic [wcrm_pkg::TOTAL_W-1:0] real_total,
	input  wire logic [wcrm_pkg::TOTAL_W-1:0] game_total,
	input  wire logic [wcrm_pkg::WARP_W-1:0]  expected_warp,
	input  wire logic [wcrm_pkg::TOL_W-1:0]   soft_tolerance,
	input  wire logic [wcrm_pkg::TOL_W-1:0]   hard_tolerance,
	output wcrm_pkg::judge_t                  verdict
);
	import wcrm_pkg::*;

	logic [DEV_W-1:0] lhs;
	logic [DEV_W-1:0] rhs;
	logic [DEV_W-1:0] dev;
	logic [DEV_W-1:0] soft_lim;
	logic [DEV_W-1:0] hard_lim;

	// game total scaled to Q.16 against warp times real total
	assign lhs = DEV_W'({game_total, {FRAC_W{1'b0}}});
	assign rhs = DEV_W'(expected_warp) * DEV_W'(real_total);
	assign dev = (lhs > rhs) ? (lhs - rhs) : (rhs - lhs);

	// tolerance bands scaled by real total
	assign soft_lim = DEV_W'(soft_tolerance) * DEV_W'(real_total);
	assign hard_lim = DEV_W'(hard_tolerance) * DEV_W'(real_total);

	assign verdict.over_hard = (dev > hard_lim);
	assign verdict.over_soft = (dev > soft_lim);

endmodule

`default_nettype wire

### hw/rtl/windowed_clock_ratio_monitor_core.sv
// flow: a request is registered in the input stage, then its result in the result
// register, where it stays while held by a stalled consumer
// throughput: one request per cycle when not stalled; combinational update and judgement
// reset: arst_n clears all control state and loads register defaults; the step
// window store is not cleared, the fill count keeps unwritten slots unread
`timescale 1ns / 1ps
`default_nettype none

module windowed_clock_ratio_monitor_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire wcrm_pkg::in_item_t             in_data,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output wcrm_pkg::out_item_t                 out_data,
	input  wire logic                           cfg_we,
	input  wire logic [wcrm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [wcrm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import wcrm_pkg::*;

	// configuration registers
	logic [WARP_W-1:0]    warp_q;
	logic [TOL_W-1:0]     soft_q;
	logic [TOL_W-1:0]     hard_q;
	logic [REQ_W-1:0]     req_q;
	logic [MINFILL_W-1:0] min_fill_q;
	logic [ARM_W-1:0]     arm_dist_q;
	logic [GAP_W-1:0]     max_gap_q;

	// input stage
	in_item_t in_s1;
	logic     in_valid_s1;
	logic     advance;

	// monitor state
	logic                armed_q, armed_n;
	logic [POS_W-1:0]    start_q, start_n;
	logic                have_q, have_n;
	logic [STAMP_W-1:0]  last_q, last_n;
	logic [SLOT_W-1:0]   oldest_q, oldest_n;
	logic [FILL_W-1:0]   fill_q, fill_n;
	logic [TOTAL_W-1:0]  rt_q, rt_n;
	logic [TOTAL_W-1:0]  gt_q, gt_n;
	logic [VIOL_W-1:0]   viol_q, viol_n;
	logic                latched_q, latched_n;

	// step window
	logic [STEP_W-1:0] real_mem_q [WINDOW_DEPTH];
	logic [STEP_W-1:0] game_mem_q [WINDOW_DEPTH];

	// result register
	out_item_t out_data_q;
	logic      out_valid_q;

	// datapath signals
	logic signed [POS_W:0] move_diff;
	logic [POS_W:0]        move_abs;
	logic [STAMP_W-1:0]    rstep;
	logic                  full;
	logic [FILL_W:0]       slot_sum;
	logic [SLOT_W-1:0]     free_slot;
	logic [SLOT_W-1:0]     slot;
	logic [SLOT_W-1:0]     oldest_inc;
	logic [STEP_W-1:0]     old_real;
	logic [STEP_W-1:0]     old_game;
	logic [TOTAL_W-1:0]    push_rt;
	logic [TOTAL_W-1:0]    push_gt;
	logic [FILL_W-1:0]     push_fill;
	logic [VIOL_W:0]       viol_p1;
	logic [VIOL_W:0]       viol_p2;
	logic                  push;
	logic                  clear;
	judge_t                verdict;

	// handshake: input stage moves on whenever the result register frees up
	assign advance   = in_valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !in_valid_s1 || !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// movement from the start point
	assign move_diff = $signed({in_s1.player_x[POS_W-1], in_s1.player_x})
		- $signed({start_q[POS_W-1], start_q});
	assign move_abs  = move_diff[POS_W] ? (POS_W+1)'(-move_diff) : (POS_W+1)'(move_diff);

	assign rstep = in_s1.now_us - last_q;

	// ring slot selection
	assign full       = (fill_q == FILL_W'(WINDOW_DEPTH));
	assign slot_sum   = (FILL_W+1)'(oldest_q) + (FILL_W+1)'(fill_q);
	assign free_slot  = (slot_sum >= (FILL_W+1)'(WINDOW_DEPTH))
		? SLOT_W'(slot_sum - (FILL_W+1)'(WINDOW_DEPTH)) : SLOT_W'(slot_sum);
	assign slot       = full ? oldest_q : free_slot;
	assign oldest_inc = (oldest_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : oldest_q + 1'b1;
	assign old_real   = full ? real_mem_q[oldest_q] : '0;
	assign old_game   = full ? game_mem_q[oldest_q] : '0;

	// totals after a push
	assign push_rt   = rt_q - TOTAL_W'(old_real) + TOTAL_W'(rstep[STEP_W-1:0]);
	assign push_gt   = gt_q - TOTAL_W'(old_game) + TOTAL_W'(in_s1.game_step_us);
	assign push_fill = full ? fill_q : fill_q + 1'b1;

	wcrm_judge u_judge (
		.real_total     (push_rt),
		.game_total     (push_gt),
		.expected_warp  (warp_q),
		.soft_tolerance (soft_q),
		.hard_tolerance (hard_q),
		.verdict        (verdict)
	);

	assign viol_p1 = (VIOL_W+1)'(viol_q) + (VIOL_W+1)'(1);
	assign viol_p2 = (VIOL_W+1)'(viol_q) + (VIOL_W+1)'(2);

	// next state for the request in the input stage
	always_comb begin
		armed_n   = armed_q;
		start_n   = start_q;
		have_n    = have_q;
		last_n    = last_q;
		oldest_n  = oldest_q;
		fill_n    = fill_q;
		rt_n      = rt_q;
		gt_n      = gt_q;
		viol_n    = viol_q;
		latched_n = latched_q;
		push      = 1'b0;
		clear     = 1'b0;

		case (in_s1.op)
			OP_FRAME: begin
				if (!latched_q && !in_s1.halted) begin
					if (!armed_q) begin
						if (move_abs >= (POS_W+1)'(arm_dist_q)) begin
							armed_n = 1'b1;
							clear   = 1'b1;
						end
						last_n = in_s1.now_us;
						have_n = 1'b1;
					end else if (!have_q) begin
						last_n = in_s1.now_us;
						have_n = 1'b1;
					end else begin
						last_n = in_s1.now_us;
						if (rstep == '0) begin
							push = 1'b0;
						end else if (rstep > STAMP_W'(max_gap_q)) begin
							clear = 1'b1;
						end else begin
							push = 1'b1;
						end
					end
				end
			end
			OP_PREPARE: begin
				armed_n = 1'b0;
				start_n = in_s1.player_x;
				have_n  = 1'b0;
				clear   = 1'b1;
			end
			OP_CLEAR_SAMPLES: begin
				have_n = 1'b0;
				clear  = 1'b1;
			end
			default: begin
				latched_n = 1'b0;
				armed_n   = 1'b0;
				start_n   = '0;
				have_n    = 1'b0;
				clear     = 1'b1;
			end
		endcase

		if (clear) begin
			oldest_n = '0;
			fill_n   = '0;
			rt_n     = '0;
			gt_n     = '0;
			viol_n   = '0;
		end

		// window push and judgement
		if (push) begin
			if (full) begin
				oldest_n = oldest_inc;
			end
			fill_n = push_fill;
			rt_n   = push_rt;
			gt_n   = push_gt;
			if ((8'(push_fill) >= 8'(min_fill_q)) && (push_rt != '0)) begin
				if (verdict.over_hard) begin
					viol_n = (viol_p2 > (VIOL_W+1)'(VIOL_MAX)) ? VIOL_MAX : viol_p2[VIOL_W-1:0];
				end else if (verdict.over_soft) begin
					viol_n = (viol_p1 > (VIOL_W+1)'(VIOL_MAX)) ? VIOL_MAX : viol_p1[VIOL_W-1:0];
				end else begin
					viol_n = '0;
				end
				if (viol_n >= VIOL_W'(req_q)) begin
					latched_n = 1'b1;
				end
			end
		end
	end

	// input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_s1 <= in_data;
		end
	end

	// state and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warp_q     <= WARP_RST;
			soft_q     <= SOFT_RST;
			hard_q     <= HARD_RST;
			req_q      <= REQ_RST;
			min_fill_q <= MINFILL_RST;
			arm_dist_q <= ARM_RST;
			max_gap_q  <= GAP_RST;
			armed_q    <= 1'b0;
			start_q    <= '0;
			have_q     <= 1'b0;
			last_q     <= '0;
			oldest_q   <= '0;
			fill_q     <= '0;
			rt_q       <= '0;
			gt_q       <= '0;
			viol_q     <= '0;
			latched_q  <= 1'b0;
		end else begin
			if (advance) begin
				armed_q   <= armed_n;
				start_q   <= start_n;
				have_q    <= have_n;
				last_q    <= last_n;
				oldest_q  <= oldest_n;
				fill_q    <= fill_n;
				rt_q      <= rt_n;
				gt_q      <= gt_n;
				viol_q    <= viol_n;
				latched_q <= latched_n;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WARP: begin
						warp_q   <= cfg_wdata[WARP_W-1:0];
						have_q   <= 1'b0;
						oldest_q <= '0;
						fill_q   <= '0;
						rt_q     <= '0;
						gt_q     <= '0;
						viol_q   <= '0;
					end
					REG_SOFT_TOL: soft_q     <= cfg_wdata[TOL_W-1:0];
					REG_HARD_TOL: hard_q     <= cfg_wdata[TOL_W-1:0];
					REG_REQ_VIOL: req_q      <= cfg_wdata[REQ_W-1:0];
					REG_MIN_FILL: min_fill_q <= cfg_wdata[MINFILL_W-1:0];
					REG_ARM_DIST: arm_dist_q <= cfg_wdata[ARM_W-1:0];
					REG_MAX_GAP:  max_gap_q  <= cfg_wdata[GAP_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// step window write
	always_ff @(posedge clk) begin
		if (advance && push) begin
			real_mem_q[slot] <= rstep[STEP_W-1:0];
			game_mem_q[slot] <= in_s1.game_step_us;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q.detected        <= latched_n;
			out_data_q.violation_count <= viol_n;
			out_data_q.is_armed        <= armed_n;
			out_data_q.window_fill     <= OUTFILL_W'(fill_n);
		end
	end

endmodule

`default_nettype wire

### hw/rtl/wcrm_checker.sv
// port-level checks for the windowed clock ratio monitor, bound to the top level
// depends on wcrm_pkg and windowed_clock_ratio_monitor_core
`timescale 1ns / 1ps
`default_nettype none

module wcrm_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire wcrm_pkg::out_item_t out_data
);
	import wcrm_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// a draining consumer never blocks new requests
	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");

	// an unarmed monitor holds no samples and no violations
	a_unarmed_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.is_armed
			|-> out_data.window_fill == '0 && out_data.violation_count == '0)
		else $error("unarmed monitor reports samples or violations");

	// violations only come from a judged, non-empty window
	a_viol_needs_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.violation_count != '0 |-> out_data.window_fill != '0)
		else $error("violations with an empty window");

endmodule

bind windowed_clock_ratio_monitor_core wcrm_checker u_wcrm_checker (.*);

`default_nettype wire
